@@ src/msgpk_pkg.sv @@
// Shared types and byte codes for the MessagePack scalar/header encoder.
package msgpk_pkg;

    // Operation codes on the request port
    typedef enum logic [3:0] {
        OP_NIL    = 4'd0,
        OP_BOOL   = 4'd1,
        OP_SINT   = 4'd2,
        OP_UINT   = 4'd3,
        OP_DOUBLE = 4'd4,
        OP_STR    = 4'd5,
        OP_ARRAY  = 4'd6,
        OP_MAP    = 4'd7,
        OP_EXT    = 4'd8
    } op_t;

    // Longest encoding in bytes
    localparam int MaxBytes = 9;
    localparam int FrameW   = 8 * MaxBytes;
    localparam int CountW   = $clog2(MaxBytes + 1);

    // MessagePack format bytes
    localparam logic [7:0] B_NIL      = 8'hc0;
    localparam logic [7:0] B_FALSE    = 8'hc2;
    localparam logic [7:0] B_TRUE     = 8'hc3;
    localparam logic [7:0] B_EXT8     = 8'hc7;
    localparam logic [7:0] B_EXT16    = 8'hc8;
    localparam logic [7:0] B_EXT32    = 8'hc9;
    localparam logic [7:0] B_FLOAT64  = 8'hcb;
    localparam logic [7:0] B_UINT8    = 8'hcc;
    localparam logic [7:0] B_UINT16   = 8'hcd;
    localparam logic [7:0] B_UINT32   = 8'hce;
    localparam logic [7:0] B_UINT64   = 8'hcf;
    localparam logic [7:0] B_INT8     = 8'hd0;
    localparam logic [7:0] B_INT16    = 8'hd1;
    localparam logic [7:0] B_INT32    = 8'hd2;
    localparam logic [7:0] B_INT64    = 8'hd3;
    localparam logic [7:0] B_FIXEXT1  = 8'hd4;
    localparam logic [7:0] B_FIXEXT2  = 8'hd5;
    localparam logic [7:0] B_FIXEXT4  = 8'hd6;
    localparam logic [7:0] B_FIXEXT8  = 8'hd7;
    localparam logic [7:0] B_FIXEXT16 = 8'hd8;
    localparam logic [7:0] B_STR8     = 8'hd9;
    localparam logic [7:0] B_STR16    = 8'hda;
    localparam logic [7:0] B_STR32    = 8'hdb;
    localparam logic [7:0] B_ARRAY16  = 8'hdc;
    localparam logic [7:0] B_ARRAY32  = 8'hdd;
    localparam logic [7:0] B_MAP16    = 8'hde;
    localparam logic [7:0] B_MAP32    = 8'hdf;
    localparam logic [7:0] B_FIXSTR   = 8'ha0;
    localparam logic [7:0] B_FIXARRAY = 8'h90;
    localparam logic [7:0] B_FIXMAP   = 8'h80;

    // One encoded item: bytes left-aligned (first byte in the top octet)
    typedef struct packed {
        logic [FrameW-1:0] bytes;
        logic [CountW-1:0] count;
    } frame_t;

endpackage

@@ src/msgpk_front.sv @@
// Front end: classifies a request and builds its left-aligned byte frame.
module msgpk_front
    import msgpk_pkg::*;
(
    input  logic [3:0]  operation,
    input  logic [63:0] value,
    input  logic [7:0]  ext_type,
    output frame_t      frame
);

    logic [31:0] len;

    assign len = value[31:0];

    // Format selection; unused codes give an empty frame
    always_comb
    begin
        frame.bytes = '0;
        frame.count = '0;
        unique case (operation)
            OP_NIL:
            begin
                frame.bytes = {B_NIL, 64'b0};
                frame.count = CountW'(1);
            end
            OP_BOOL:
            begin
                frame.bytes = {((value != 64'd0) ? B_TRUE : B_FALSE), 64'b0};
                frame.count = CountW'(1);
            end
            OP_SINT, OP_UINT:
            begin
                if (operation == OP_UINT || !value[63])
                begin
                    priority if (value <= 64'h7f)
                    begin
                        frame.bytes = {value[7:0], 64'b0};
                        frame.count = CountW'(1);
                    end
                    else if (value <= 64'hff)
                    begin
                        frame.bytes = {B_UINT8, value[7:0], 56'b0};
                        frame.count = CountW'(2);
                    end
                    else if (value <= 64'hffff)
                    begin
                        frame.bytes = {B_UINT16, value[15:0], 48'b0};
                        frame.count = CountW'(3);
                    end
                    else if (value <= 64'hffff_ffff)
                    begin
                        frame.bytes = {B_UINT32, value[31:0], 32'b0};
                        frame.count = CountW'(5);
                    end
                    else
                    begin
                        frame.bytes = {B_UINT64, value};
                        frame.count = CountW'(9);
                    end
                end
                else
                begin
                    // negative: narrowest two's complement form
                    priority if (value >= 64'hffff_ffff_ffff_ffe0)
                    begin
                        frame.bytes = {value[7:0], 64'b0};
                        frame.count = CountW'(1);
                    end
                    else if (value >= 64'hffff_ffff_ffff_ff80)
                    begin
                        frame.bytes = {B_INT8, value[7:0], 56'b0};
                        frame.count = CountW'(2);
                    end
                    else if (value >= 64'hffff_ffff_ffff_8000)
                    begin
                        frame.bytes = {B_INT16, value[15:0], 48'b0};
                        frame.count = CountW'(3);
                    end
                    else if (value >= 64'hffff_ffff_8000_0000)
                    begin
                        frame.bytes = {B_INT32, value[31:0], 32'b0};
                        frame.count = CountW'(5);
                    end
                    else
                    begin
                        frame.bytes = {B_INT64, value};
                        frame.count = CountW'(9);
                    end
                end
            end
            OP_DOUBLE:
            begin
                frame.bytes = {B_FLOAT64, value};
                frame.count = CountW'(9);
            end
            OP_STR:
            begin
                priority if (len < 32'd32)
                begin
                    frame.bytes = {(B_FIXSTR | {3'b0, len[4:0]}), 64'b0};
                    frame.count = CountW'(1);
                end
                else if (len < 32'd256)
                begin
                    frame.bytes = {B_STR8, len[7:0], 56'b0};
                    frame.count = CountW'(2);
                end
                else if (len < 32'd65536)
                begin
                    frame.bytes = {B_STR16, len[15:0], 48'b0};
                    frame.count = CountW'(3);
                end
                else
                begin
                    frame.bytes = {B_STR32, len, 32'b0};
                    frame.count = CountW'(5);
                end
            end
            OP_ARRAY, OP_MAP:
            begin
                priority if (len < 32'd16)
                begin
                    frame.bytes = {(((operation == OP_MAP) ? B_FIXMAP : B_FIXARRAY)
                                    | {4'b0, len[3:0]}), 64'b0};
                    frame.count = CountW'(1);
                end
                else if (len < 32'd65536)
                begin
                    frame.bytes = {((operation == OP_MAP) ? B_MAP16 : B_ARRAY16),
                                   len[15:0], 48'b0};
                    frame.count = CountW'(3);
                end
                else
                begin
                    frame.bytes = {((operation == OP_MAP) ? B_MAP32 : B_ARRAY32),
                                   len, 32'b0};
                    frame.count = CountW'(5);
                end
            end
            OP_EXT:
            begin
                priority if (len <= 32'd1)
                begin
                    // zero length carries one 0x00 pad byte after the type
                    frame.bytes = {B_FIXEXT1, ext_type, 8'h00, 48'b0};
                    frame.count = (len == 32'd0) ? CountW'(3) : CountW'(2);
                end
                else if (len == 32'd2)
                begin
                    frame.bytes = {B_FIXEXT2, ext_type, 56'b0};
                    frame.count = CountW'(2);
                end
                else if (len == 32'd4)
                begin
                    frame.bytes = {B_FIXEXT4, ext_type, 56'b0};
                    frame.count = CountW'(2);
                end
                else if (len == 32'd8)
                begin
                    frame.bytes = {B_FIXEXT8, ext_type, 56'b0};
                    frame.count = CountW'(2);
                end
                else if (len == 32'd16)
                begin
                    frame.bytes = {B_FIXEXT16, ext_type, 56'b0};
                    frame.count = CountW'(2);
                end
                else if (len < 32'd256)
                begin
                    frame.bytes = {B_EXT8, len[7:0], ext_type, 48'b0};
                    frame.count = CountW'(3);
                end
                else if (len < 32'd65536)
                begin
                    frame.bytes = {B_EXT16, len[15:0], ext_type, 40'b0};
                    frame.count = CountW'(4);
                end
                else
                begin
                    frame.bytes = {B_EXT32, len, ext_type, 24'b0};
                    frame.count = CountW'(6);
                end
            end
            default:
            begin
                frame.bytes = '0;
                frame.count = '0;
            end
        endcase
    end

endmodule

@@ src/msgpk_queue.sv @@
// Two-entry frame queue between the classifier and the byte serializer.
module msgpk_queue
    import msgpk_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_frame,
    input  logic   pop,
    output frame_t head_frame,
    output logic   not_empty,
    output logic   full
);

    frame_t     entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign head_frame = entry_reg[rd_ptr_reg];
    assign not_empty  = (fill_reg != 2'd0);
    assign full       = (fill_reg == 2'd2);

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

@@ src/msgpk_back.sv @@
// Back end: shifts a frame out one byte per cycle with a last marker.
module msgpk_back
    import msgpk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  frame_t     head_frame,
    input  logic       not_empty,
    output logic       pop,
    output logic       strobe,
    output logic [7:0] out_byte,
    output logic       last_byte
);

    logic [FrameW-1:0] shift_reg, shift_next;
    logic [CountW-1:0] left_reg, left_next;

    // Load the next frame as the current one sends its final byte, or while idle
    assign pop = not_empty && (left_reg <= CountW'(1));

    always_comb
    begin
        shift_next = shift_reg;
        left_next  = left_reg;
        if (pop)
        begin
            shift_next = head_frame.bytes;
            left_next  = head_frame.count;
        end
        else if (left_reg != '0)
        begin
            shift_next = {shift_reg[FrameW-9:0], 8'h00};
            left_next  = left_reg - CountW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign strobe    = (left_reg != '0);
    assign last_byte = (left_reg == CountW'(1));
    assign out_byte  = shift_reg[FrameW-1:FrameW-8];

endmodule

@@ src/msgpack_scalar_header_encoder.sv @@
// Top level of the MessagePack scalar and header encoder.
//
// Request channel: operation, value and ext_type are taken at a rising edge
// where start is high and busy is low. busy is high while the two-entry
// frame queue is full.
// Result channel: one encoded byte per cycle on out_byte, marked by strobe;
// last_byte is high on the final byte of each item. There is no back
// pressure: every strobed byte is a transfer.
// An accepted item is written into the frame queue, then loaded into the
// output shift register, whose top byte drives out_byte. The output shift
// register sends one byte per cycle; an item has 1 to 9 bytes, with 9 for
// doubles and 64-bit integers. Items with unused operation codes are
// accepted and produce no bytes.
// Reset: rst_n clears the queue and the output counter; strobe is low
// until the first item arrives.
module msgpack_scalar_header_encoder
    import msgpk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  operation,
    input  logic [63:0] value,
    input  logic [7:0]  ext_type,
    output logic        strobe,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    frame_t new_frame;
    frame_t head_frame;
    logic   q_full;
    logic   q_not_empty;
    logic   q_push;
    logic   q_pop;

    msgpk_front u_front (
        .operation (operation),
        .value     (value),
        .ext_type  (ext_type),
        .frame     (new_frame)
    );

    // Empty frames are dropped at the queue input
    assign busy   = q_full;
    assign q_push = start && !q_full && (new_frame.count != '0);

    msgpk_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_frame (new_frame),
        .pop        (q_pop),
        .head_frame (head_frame),
        .not_empty  (q_not_empty),
        .full       (q_full)
    );

    msgpk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_frame (head_frame),
        .not_empty  (q_not_empty),
        .pop        (q_pop),
        .strobe     (strobe),
        .out_byte   (out_byte),
        .last_byte  (last_byte)
    );

endmodule
